/* hdl/mutex_condvar_wait_queue_unit_top_macros.svh */
// Assertion macros used by the datapath RTL of the mutex unit.
`ifndef MUTEX_CONDVAR_WAIT_QUEUE_UNIT_TOP_MACROS_SVH
`define MUTEX_CONDVAR_WAIT_QUEUE_UNIT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent check that is switched off while reset is high.
`define MCWQ_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that holds in every cycle, reset included.
`define MCWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCWQ_ASSERT_RST(lbl, clk, rst, prop, msg)
`define MCWQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hdl/mcwq_pkg.sv */
`timescale 1ns / 1ps

package mcwq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TASK_BITS    = 8;
   localparam int TASK_ID_BITS = 8;
   localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS     = CNT_BITS + 1;

   typedef enum logic [1:0] {
      REQ_LOCK   = 2'd0,
      REQ_UNLOCK = 2'd1,
      REQ_WAIT   = 2'd2,
      REQ_SIGNAL = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      OUT_GRANTED  = 3'd0,
      OUT_BLOCKED  = 3'd1,
      OUT_RETRY    = 3'd2,
      OUT_DONE     = 3'd3,
      OUT_OVERFLOW = 3'd4
   } outcome_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

/* hdl/mcwq_req_if.sv */
`timescale 1ns / 1ps

interface mcwq_req_if;
   import mcwq_pkg::*;

   logic                    valid;
   logic                    ready;
   req_code_type            req_type;
   logic [TASK_ID_BITS-1:0] task_id;

   modport source (output valid, output req_type, output task_id, input ready);
   modport sink   (input valid, input req_type, input task_id, output ready);
endinterface

/* hdl/mcwq_rsp_if.sv */
`timescale 1ns / 1ps

interface mcwq_rsp_if;
   import mcwq_pkg::*;

   logic                    valid;
   logic                    ready;
   outcome_type             outcome;
   logic                    wake_valid;
   logic [TASK_ID_BITS-1:0] wake_task;

   modport source (output valid, output outcome, output wake_valid, output wake_task,
                   input ready);
   modport sink   (input valid, input outcome, input wake_valid, input wake_task,
                   output ready);
endinterface

/* hdl/mcwq_ram.sv */
`timescale 1ns / 1ps

module mcwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mcwq_ctrl.sv */
`timescale 1ns / 1ps

module mcwq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mcwq_pkg::dp_status_type status,
   output mcwq_pkg::ctl_cmd_type   cmd
);
   import mcwq_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No word is taken while reset is held.
            req_ready = ~reset;
            if (req_valid && req_ready) begin
               // The queue heads are read now; the word is resolved in ST_EXEC once the result is free.
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/mcwq_dp.sv */
`timescale 1ns / 1ps
`include "mutex_condvar_wait_queue_unit_top_macros.svh"

module mcwq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  mcwq_pkg::ctl_cmd_type             cmd,
   output mcwq_pkg::dp_status_type           status,
   input  mcwq_pkg::req_code_type            req_type,
   input  logic [mcwq_pkg::TASK_ID_BITS-1:0] req_task_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mcwq_pkg::outcome_type             rsp_outcome,
   output logic                              rsp_wake_valid,
   output logic [mcwq_pkg::TASK_ID_BITS-1:0] rsp_wake_task,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);
   import mcwq_pkg::*;

   logic blocking_mode_ff;
   logic mutex_held_ff, mutex_held_in;

   logic [PTR_BITS-1:0] m_head_ff, m_head_in;
   logic [CNT_BITS-1:0] m_cnt_ff, m_cnt_in;
   logic [PTR_BITS-1:0] c_head_ff, c_head_in;
   logic [CNT_BITS-1:0] c_cnt_ff, c_cnt_in;

   req_code_type         req_type_ff;
   logic [TASK_BITS-1:0] task_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   outcome_type             rsp_outcome_ff, rsp_outcome_in;
   logic                    rsp_wake_valid_ff, rsp_wake_valid_in;
   logic [TASK_ID_BITS-1:0] rsp_wake_task_ff;
   logic [TASK_BITS-1:0]    wake_task_in;

   logic                 m_push, m_pop, c_push, c_pop;
   logic [TASK_BITS-1:0] m_rd_data, c_rd_data;
   logic [PTR_BITS-1:0]  m_tail, c_tail;
   logic                 m_full, c_full;

   function automatic logic [PTR_BITS-1:0] tail_of(input logic [PTR_BITS-1:0] head,
                                                   input logic [CNT_BITS-1:0] cnt);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(head) + SUM_BITS'(cnt);
      if (sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         sum = sum - SUM_BITS'(QUEUE_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] nxt;
      if (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_BITS'(1);
      end
      return nxt;
   endfunction

   assign m_tail = tail_of(m_head_ff, m_cnt_ff);
   assign c_tail = tail_of(c_head_ff, c_cnt_ff);
   assign m_full = (m_cnt_ff == CNT_BITS'(QUEUE_DEPTH));
   assign c_full = (c_cnt_ff == CNT_BITS'(QUEUE_DEPTH));

   mcwq_ram #(.WIDTH(TASK_BITS), .DEPTH(QUEUE_DEPTH)) u_mutex_ram (
      .clock   (clock),
      .wr_en   (m_push),
      .wr_addr (m_tail),
      .wr_data (task_ff),
      .rd_en   (cmd.capture),
      .rd_addr (m_head_ff),
      .rd_data (m_rd_data)
   );

   mcwq_ram #(.WIDTH(TASK_BITS), .DEPTH(QUEUE_DEPTH)) u_cond_ram (
      .clock   (clock),
      .wr_en   (c_push),
      .wr_addr (c_tail),
      .wr_data (task_ff),
      .rd_en   (cmd.capture),
      .rd_addr (c_head_ff),
      .rd_data (c_rd_data)
   );

   always_comb begin
      m_push            = 1'b0;
      m_pop             = 1'b0;
      c_push            = 1'b0;
      c_pop             = 1'b0;
      mutex_held_in     = mutex_held_ff;
      rsp_outcome_in    = OUT_DONE;
      rsp_wake_valid_in = 1'b0;
      wake_task_in      = '0;
      case (req_type_ff)
         REQ_LOCK: begin
            if (!mutex_held_ff) begin
               mutex_held_in  = 1'b1;
               rsp_outcome_in = OUT_GRANTED;
            end else if (!blocking_mode_ff) begin
               rsp_outcome_in = OUT_RETRY;
            end else if (m_full) begin
               rsp_outcome_in = OUT_OVERFLOW;
            end else begin
               m_push         = 1'b1;
               rsp_outcome_in = OUT_BLOCKED;
            end
         end
         REQ_UNLOCK, REQ_WAIT: begin
            if (req_type_ff == REQ_WAIT && c_full) begin
               // A full condition queue leaves the mutex untouched as well.
               rsp_outcome_in = OUT_OVERFLOW;
            end else begin
               if (blocking_mode_ff && m_cnt_ff != '0) begin
                  // Hand the lock straight to the oldest waiter.
                  m_pop             = 1'b1;
                  mutex_held_in     = 1'b1;
                  rsp_wake_valid_in = 1'b1;
                  wake_task_in      = m_rd_data;
               end else begin
                  mutex_held_in = 1'b0;
               end
               if (req_type_ff == REQ_WAIT) begin
                  c_push         = 1'b1;
                  rsp_outcome_in = OUT_BLOCKED;
               end
            end
         end
         REQ_SIGNAL: begin
            if (c_cnt_ff != '0) begin
               c_pop             = 1'b1;
               rsp_wake_valid_in = 1'b1;
               wake_task_in      = c_rd_data;
            end
         end
         default: begin
            rsp_outcome_in = OUT_DONE;
         end
      endcase

      m_push = m_push & cmd.commit;
      m_pop  = m_pop & cmd.commit;
      c_push = c_push & cmd.commit;
      c_pop  = c_pop & cmd.commit;

      m_head_in = m_pop ? next_ptr(m_head_ff) : m_head_ff;
      c_head_in = c_pop ? next_ptr(c_head_ff) : c_head_ff;
      m_cnt_in  = m_cnt_ff;
      c_cnt_in  = c_cnt_ff;
      if (m_push) begin
         m_cnt_in = m_cnt_ff + CNT_BITS'(1);
      end else if (m_pop) begin
         m_cnt_in = m_cnt_ff - CNT_BITS'(1);
      end
      if (c_push) begin
         c_cnt_in = c_cnt_ff + CNT_BITS'(1);
      end else if (c_pop) begin
         c_cnt_in = c_cnt_ff - CNT_BITS'(1);
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocking_mode_ff <= 1'b1;
         mutex_held_ff    <= 1'b0;
         m_head_ff        <= '0;
         m_cnt_ff         <= '0;
         c_head_ff        <= '0;
         c_cnt_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blocking_mode_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            mutex_held_ff <= mutex_held_in;
         end
         m_head_ff    <= m_head_in;
         m_cnt_ff     <= m_cnt_in;
         c_head_ff    <= c_head_in;
         c_cnt_ff     <= c_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         task_ff     <= req_task_id[TASK_BITS-1:0];
      end
      if (cmd.commit) begin
         rsp_outcome_ff    <= rsp_outcome_in;
         rsp_wake_valid_ff <= rsp_wake_valid_in;
         rsp_wake_task_ff  <= TASK_ID_BITS'(wake_task_in);
      end
   end

   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_wake_valid  = rsp_wake_valid_ff;
   assign rsp_wake_task   = rsp_wake_task_ff;

   `MCWQ_ASSERT_RST(a_mcnt_bound, clock, reset, m_cnt_ff <= CNT_BITS'(QUEUE_DEPTH), "mutex queue count exceeds depth")
   `MCWQ_ASSERT_RST(a_ccnt_bound, clock, reset, c_cnt_ff <= CNT_BITS'(QUEUE_DEPTH), "condition queue count exceeds depth")
   `MCWQ_ASSERT_RST(a_commit_room, clock, reset, cmd.commit |-> (!rsp_valid_ff || rsp_ready), "result overwritten before it was taken")
   `MCWQ_ASSERT_RST(a_grant_holds, clock, reset, (cmd.commit && rsp_outcome_in == OUT_GRANTED) |=> mutex_held_ff, "grant did not mark the mutex held")
   `MCWQ_ASSERT_RST(a_mcnt_quiet, clock, reset, !cmd.commit |=> $stable(m_cnt_ff), "mutex queue count moved without a commit")

endmodule

/* hdl/mutex_condvar_wait_queue_unit_top.sv */
// Mutex with one condition variable and two FIFO wait queues.
// A request word is taken in ST_IDLE and its result word is registered from ST_EXEC,
// which holds while the previous result word is still waiting to be taken.
// A new request word is taken only in ST_IDLE, once the previous one is done; the queue
// heads are read from the RAM as it is taken and updated with the result in ST_EXEC.
// Reset: synchronous, active high; mutex free, both queues empty, blocking mode set.
`timescale 1ns / 1ps

module mutex_condvar_wait_queue_unit_top (
   input  logic            clock,
   input  logic            reset,
   mcwq_req_if.sink        req_if,
   mcwq_rsp_if.source      rsp_if,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);
   import mcwq_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   mcwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcwq_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_if.req_type),
      .req_task_id    (req_if.task_id),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_outcome    (rsp_if.outcome),
      .rsp_wake_valid (rsp_if.wake_valid),
      .rsp_wake_task  (rsp_if.wake_task),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

endmodule
